// File: sv/pgpu_pkg.sv
// ----------------------------------------------------------------------------
// pgpu_pkg: shared types for the planar geometry predicate unit
// Predicate codes, the field width of the coordinate ports and the sign word
// that each orientation unit hands to the top level.
// ----------------------------------------------------------------------------
package pgpu_pkg;

  // Width of every coordinate port of the top level
  localparam int unsigned FieldW = 32;

  typedef enum logic [2:0] {
    FN_COLLINEAR    = 3'd0,
    FN_LEFT         = 3'd1,
    FN_LEFT_OR_ON   = 3'd2,
    FN_RIGHT        = 3'd3,
    FN_IN_CONE      = 3'd4,
    FN_BETWEEN      = 3'd5,
    FN_CROSS_PROPER = 3'd6,
    FN_INTERSECT    = 3'd7
  } func_e;

  // Sign of an exact cross product
  typedef struct packed {
    logic neg;
    logic zero;
  } orient_sign_t;

endpackage

// File: sv/pgpu_orient.sv
// ----------------------------------------------------------------------------
// pgpu_orient: exact orientation sign of three points
// Three register stages: coordinate differences, the two partial products,
// and the sign of their difference (b - a) x (c - a).
// ----------------------------------------------------------------------------
module pgpu_orient #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic signed [COORD_BITS-1:0]   a_x_i,
  input  logic signed [COORD_BITS-1:0]   a_y_i,
  input  logic signed [COORD_BITS-1:0]   b_x_i,
  input  logic signed [COORD_BITS-1:0]   b_y_i,
  input  logic signed [COORD_BITS-1:0]   c_x_i,
  input  logic signed [COORD_BITS-1:0]   c_y_i,
  output pgpu_pkg::orient_sign_t         sign_o
);
  import pgpu_pkg::*;

  localparam int unsigned DiffW = COORD_BITS + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned CrossW = ProdW + 1;

  logic signed [DiffW-1:0]  bax_q, cay_q, cax_q, bay_q;
  logic signed [ProdW-1:0]  prod1_q, prod2_q;
  logic signed [CrossW-1:0] cross_d;
  orient_sign_t             sign_d, sign_q;

  always_ff @(posedge clk_i) begin
    bax_q <= DiffW'(b_x_i) - DiffW'(a_x_i);
    cay_q <= DiffW'(c_y_i) - DiffW'(a_y_i);
    cax_q <= DiffW'(c_x_i) - DiffW'(a_x_i);
    bay_q <= DiffW'(b_y_i) - DiffW'(a_y_i);
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= ProdW'(bax_q) * ProdW'(cay_q);
    prod2_q <= ProdW'(cax_q) * ProdW'(bay_q);
  end

  always_comb begin
    cross_d     = CrossW'(prod1_q) - CrossW'(prod2_q);
    sign_d.neg  = cross_d[CrossW-1];
    sign_d.zero = (cross_d == '0);
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
  end

  assign sign_o = sign_q;

endmodule

// File: sv/planar_geometry_predicate_unit.sv
// ----------------------------------------------------------------------------
// planar_geometry_predicate_unit: orientation and segment predicates
// Evaluates one planar predicate over up to four integer points per word.
// ----------------------------------------------------------------------------
// Takes one word per clock while busy is low and returns its verdict on
// verdict_o, flagged by done_o, in order, one verdict per word. The pipeline
// stages are the input register, coordinate differences, partial products,
// cross-product sign and verdict register.
// busy is high only in the first cycle after reset; the result side has no
// stall, so done_o must be taken in the cycle it is shown.
module planar_geometry_predicate_unit #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      func_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt0_x_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt0_y_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt1_x_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt1_y_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt2_x_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt2_y_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt3_x_i,
  input  logic [pgpu_pkg::FieldW-1:0]     pt3_y_i,
  output logic                            done_o,
  output logic                            verdict_o
);
  import pgpu_pkg::*;

  localparam int unsigned NumBetween = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Closed range test of c against segment a-b, by x unless the segment
  // is vertical
  function automatic logic in_range(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                    coord_t cx, coord_t cy);
    logic res;
    if (ax != bx) begin
      res = (ax <= cx && cx <= bx) || (bx <= cx && cx <= ax);
    end else begin
      res = (ay <= cy && cy <= by) || (by <= cy && cy <= ay);
    end
    return res;
  endfunction

  logic                  busy_q;
  logic                  accept;
  logic                  vld0_q, vld1_q, vld2_q, vld3_q, done_q;
  func_e                 func0_q, func1_q, func2_q, func3_q;
  coord_t                p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q, p3x_q, p3y_q;
  logic [NumBetween-1:0] rng_d, rng1_q, rng2_q, rng3_q;
  orient_sign_t          s012, s013, s230, s231;
  logic                  left012, left013, left230, left231;
  logic [1:0]            cone_cnt;
  logic                  cross_ok;
  logic                  verdict_d, verdict_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // Hold busy for the first cycle out of reset only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld0_q <= accept;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      done_q <= vld3_q;
    end
  end

  // Input register: keep only the low COORD_BITS of each coordinate
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func0_q <= func_e'(func_i);
      p0x_q   <= coord_t'(pt0_x_i[COORD_BITS-1:0]);
      p0y_q   <= coord_t'(pt0_y_i[COORD_BITS-1:0]);
      p1x_q   <= coord_t'(pt1_x_i[COORD_BITS-1:0]);
      p1y_q   <= coord_t'(pt1_y_i[COORD_BITS-1:0]);
      p2x_q   <= coord_t'(pt2_x_i[COORD_BITS-1:0]);
      p2y_q   <= coord_t'(pt2_y_i[COORD_BITS-1:0]);
      p3x_q   <= coord_t'(pt3_x_i[COORD_BITS-1:0]);
      p3y_q   <= coord_t'(pt3_y_i[COORD_BITS-1:0]);
    end
  end

  always_comb begin
    rng_d[0] = in_range(p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q);
    rng_d[1] = in_range(p0x_q, p0y_q, p1x_q, p1y_q, p3x_q, p3y_q);
    rng_d[2] = in_range(p2x_q, p2y_q, p3x_q, p3y_q, p0x_q, p0y_q);
    rng_d[3] = in_range(p2x_q, p2y_q, p3x_q, p3y_q, p1x_q, p1y_q);
  end

  // Delay opcode and range bits to meet the orientation signs
  always_ff @(posedge clk_i) begin
    func1_q <= func0_q;
    func2_q <= func1_q;
    func3_q <= func2_q;
    rng1_q  <= rng_d;
    rng2_q  <= rng1_q;
    rng3_q  <= rng2_q;
  end

  pgpu_orient #(.COORD_BITS(COORD_BITS)) u_orient_012 (
    .clk_i (clk_i),
    .a_x_i (p0x_q), .a_y_i (p0y_q),
    .b_x_i (p1x_q), .b_y_i (p1y_q),
    .c_x_i (p2x_q), .c_y_i (p2y_q),
    .sign_o(s012)
  );

  pgpu_orient #(.COORD_BITS(COORD_BITS)) u_orient_013 (
    .clk_i (clk_i),
    .a_x_i (p0x_q), .a_y_i (p0y_q),
    .b_x_i (p1x_q), .b_y_i (p1y_q),
    .c_x_i (p3x_q), .c_y_i (p3y_q),
    .sign_o(s013)
  );

  pgpu_orient #(.COORD_BITS(COORD_BITS)) u_orient_230 (
    .clk_i (clk_i),
    .a_x_i (p2x_q), .a_y_i (p2y_q),
    .b_x_i (p3x_q), .b_y_i (p3y_q),
    .c_x_i (p0x_q), .c_y_i (p0y_q),
    .sign_o(s230)
  );

  pgpu_orient #(.COORD_BITS(COORD_BITS)) u_orient_231 (
    .clk_i (clk_i),
    .a_x_i (p2x_q), .a_y_i (p2y_q),
    .b_x_i (p3x_q), .b_y_i (p3y_q),
    .c_x_i (p1x_q), .c_y_i (p1y_q),
    .sign_o(s231)
  );

  // Cone terms reuse the same signs: a cyclic shift keeps the sign of an
  // orientation, a swap of two points flips it
  always_comb begin
    left012  = !s012.neg && !s012.zero;
    left013  = !s013.neg && !s013.zero;
    left230  = !s230.neg && !s230.zero;
    left231  = !s231.neg && !s231.zero;
    cone_cnt = 2'(left231) + 2'(left013) + 2'(s012.neg);
    cross_ok = !s012.zero && !s013.zero && !s230.zero && !s231.zero &&
               (left012 != left013) && (left230 != left231);
    case (func3_q)
      FN_COLLINEAR:    verdict_d = s012.zero;
      FN_LEFT:         verdict_d = left012;
      FN_LEFT_OR_ON:   verdict_d = !s012.neg;
      FN_RIGHT:        verdict_d = s012.neg;
      FN_IN_CONE:      verdict_d = cone_cnt[1];
      FN_BETWEEN:      verdict_d = s012.zero && rng3_q[0];
      FN_CROSS_PROPER: verdict_d = cross_ok;
      FN_INTERSECT:    verdict_d = cross_ok ||
                                   (s012.zero && rng3_q[0]) ||
                                   (s013.zero && rng3_q[1]) ||
                                   (s230.zero && rng3_q[2]) ||
                                   (s231.zero && rng3_q[3]);
      default:         verdict_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign done_o    = done_q;
  assign verdict_o = verdict_q;

  a_ready_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose after leaving reset");

  a_word_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o)
    else $error("accepted word produced no result five cycles later");

  a_result_has_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, 5)) |-> $past(start && !busy, 5))
    else $error("result strobe without an accepted word");

  a_sign_coherent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> !(s012.neg && s012.zero) && !(s231.neg && s231.zero))
    else $error("orientation sign both negative and zero");

endmodule
